@@ rtl/core/dbb_pkg.sv @@
// ----------------------------------------------------------------------------
// dbb_pkg: shared types and constants of the distance blink bargraph
// Beat payload structs, register map codes and the bar height function.
// ----------------------------------------------------------------------------
package dbb_pkg;

  localparam int HIST_DEPTH  = 8;
  localparam int DIST_W      = 10;
  localparam int LEVEL_W     = 8;
  localparam int BAR_W       = 4;
  localparam int COUNT_W     = 12;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [DIST_W-1:0]  THRESH_RESET = 10'd60;
  localparam logic [LEVEL_W-1:0] BLINK_LEVEL  = 8'd200;
  localparam logic [COUNT_W-1:0] PERIOD_BASE  = 12'd100;
  localparam logic [COUNT_W-1:0] ELAPSED_MAX  = 12'd4095;
  localparam logic [COUNT_W-1:0] PERIOD_MAX   = 12'd2401;
  localparam logic [BAR_W-1:0]   BAR_FULL     = 4'd8;

  // item kinds
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // register word indexes
  localparam logic REG_NEAR_THRESHOLD = 1'b0;

  typedef struct packed {
    logic              func;
    logic [DIST_W-1:0] distance_cm;
  } dbb_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] led_red;
    logic [LEVEL_W-1:0] led_green;
    logic               led_lit;
    logic [BAR_W-1:0]   bar_0;
    logic [BAR_W-1:0]   bar_1;
    logic [BAR_W-1:0]   bar_2;
    logic [BAR_W-1:0]   bar_3;
    logic [BAR_W-1:0]   bar_4;
    logic [BAR_W-1:0]   bar_5;
    logic [BAR_W-1:0]   bar_6;
    logic [BAR_W-1:0]   bar_7;
  } dbb_out_t;

  // max(0, 8 - d/10); d/10 by reciprocal 205/2048, exact for d < 80
  function automatic logic [BAR_W-1:0] bar_height(input logic [DIST_W-1:0] d);
    logic [14:0] prod;
    logic [3:0]  q;
    prod = 15'(d[6:0]) * 15'd205;
    q    = prod[14:11];
    if (d >= 10'd80) begin
      bar_height = '0;
    end else begin
      bar_height = BAR_FULL - q;
    end
  endfunction

  // d*9/4 + 100, at most 2401
  function automatic logic [COUNT_W-1:0] blink_period(input logic [DIST_W-1:0] d);
    logic [13:0] nine_d;
    nine_d       = {1'b0, d, 3'b000} + 14'(d);
    blink_period = 12'(nine_d[13:2]) + PERIOD_BASE;
  endfunction

endpackage

@@ rtl/core/dbb_cfg.sv @@
// ----------------------------------------------------------------------------
// dbb_cfg: configuration register file
// APB-style slave holding the near threshold; zero wait states.
// ----------------------------------------------------------------------------
module dbb_cfg
  import dbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [DIST_W-1:0] near_threshold
);

  logic              wr_en;
  logic [DIST_W-1:0] thresh_r;
  logic [DIST_W-1:0] thresh_nxt;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // write decode, unknown words ignored
  always_comb begin
    thresh_nxt = thresh_r;
    if (wr_en && (paddr[ADDR_W-1] == REG_NEAR_THRESHOLD)) begin
      thresh_nxt = pwdata[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else begin
      thresh_r <= thresh_nxt;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1] == REG_NEAR_THRESHOLD) begin
      prdata = DATA_W'(thresh_r);
    end
  end

  assign near_threshold = thresh_r;

endmodule

@@ rtl/core/dbb_engine.sv @@
// ----------------------------------------------------------------------------
// dbb_engine: blink timer, color select and bar history
// Updates state for one beat and forms its result from the new state.
// ----------------------------------------------------------------------------
module dbb_engine
  import dbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  dbb_in_t           item,
  input  logic [DIST_W-1:0] near_threshold,
  output dbb_out_t          result
);

  logic                enabled_r, enabled_nxt;
  logic                lit_r, lit_nxt;
  logic [COUNT_W-1:0]  elapsed_r, elapsed_nxt;
  logic [COUNT_W-1:0]  period_r, period_nxt;
  logic [LEVEL_W-1:0]  pend_red_r, pend_red_nxt;
  logic [LEVEL_W-1:0]  pend_green_r, pend_green_nxt;
  logic [LEVEL_W-1:0]  shown_red_r, shown_red_nxt;
  logic [LEVEL_W-1:0]  shown_green_r, shown_green_nxt;
  logic [BAR_W-1:0]    hist_r   [HIST_DEPTH];
  logic [BAR_W-1:0]    hist_nxt [HIST_DEPTH];
  logic [COUNT_W-1:0]  count_inc;

  // saturating tick count
  assign count_inc = (elapsed_r < ELAPSED_MAX) ? elapsed_r + 12'd1 : elapsed_r;

  // next state for the beat in hand
  always_comb begin
    enabled_nxt     = enabled_r;
    lit_nxt         = lit_r;
    elapsed_nxt     = elapsed_r;
    period_nxt      = period_r;
    pend_red_nxt    = pend_red_r;
    pend_green_nxt  = pend_green_r;
    shown_red_nxt   = shown_red_r;
    shown_green_nxt = shown_green_r;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_nxt[i] = hist_r[i];
    end
    if (item.func == FUNC_SAMPLE) begin
      enabled_nxt = 1'b1;
      period_nxt  = blink_period(item.distance_cm);
      if (item.distance_cm < near_threshold) begin
        pend_red_nxt   = BLINK_LEVEL;
        pend_green_nxt = '0;
      end else begin
        pend_red_nxt   = '0;
        pend_green_nxt = BLINK_LEVEL;
      end
      // shift history, newest at column 0
      hist_nxt[0] = bar_height(item.distance_cm);
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_nxt[i] = hist_r[i-1];
      end
    end else begin
      elapsed_nxt = count_inc;
      if (enabled_r && (count_inc >= period_r)) begin
        if (lit_r) begin
          shown_red_nxt   = '0;
          shown_green_nxt = '0;
        end else begin
          shown_red_nxt   = pend_red_r;
          shown_green_nxt = pend_green_r;
        end
        lit_nxt     = !lit_r;
        elapsed_nxt = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r     <= 1'b0;
      lit_r         <= 1'b0;
      elapsed_r     <= '0;
      period_r      <= '0;
      pend_red_r    <= '0;
      pend_green_r  <= '0;
      shown_red_r   <= '0;
      shown_green_r <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= BAR_FULL;
      end
    end else if (step) begin
      enabled_r     <= enabled_nxt;
      lit_r         <= lit_nxt;
      elapsed_r     <= elapsed_nxt;
      period_r      <= period_nxt;
      pend_red_r    <= pend_red_nxt;
      pend_green_r  <= pend_green_nxt;
      shown_red_r   <= shown_red_nxt;
      shown_green_r <= shown_green_nxt;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= hist_nxt[i];
      end
    end
  end

  // result from the updated state
  always_comb begin
    result.led_red   = lit_nxt ? shown_red_nxt : '0;
    result.led_green = lit_nxt ? shown_green_nxt : '0;
    result.led_lit   = lit_nxt;
    result.bar_0     = hist_nxt[0];
    result.bar_1     = hist_nxt[1];
    result.bar_2     = hist_nxt[2];
    result.bar_3     = hist_nxt[3];
    result.bar_4     = hist_nxt[4];
    result.bar_5     = hist_nxt[5];
    result.bar_6     = hist_nxt[6];
    result.bar_7     = hist_nxt[7];
  end

`ifndef SYNTHESIS
  // LED phase only moves on a tick beat
  a_lit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(step && item.func == FUNC_TICK) |=> $stable(lit_r))
    else $error("lit phase changed without a tick");

  // period always comes from a sample, never beyond the largest one
  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.func == FUNC_SAMPLE |=> period_r >= PERIOD_BASE && period_r <= PERIOD_MAX)
    else $error("blink period out of range");

  // newest and oldest bars never above full
  a_bar_range: assert property (@(posedge clk) disable iff (!rst_n)
    hist_r[0] <= BAR_FULL && hist_r[HIST_DEPTH-1] <= BAR_FULL)
    else $error("bar height above full");
`endif

endmodule

@@ rtl/core/distance_blink_bargraph_top.sv @@
// ----------------------------------------------------------------------------
// distance_blink_bargraph_top: parking-style distance indicator
// Input register, update engine, result register and config port.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per item; func 0 is a 1 ms tick, func 1 a distance
//           sample in cm. Every beat yields exactly one result beat.
//   out_* : LED color, lit flag and eight bar heights after the update.
//   psel/penable/pwrite/paddr/pwdata : pready is tied high; near threshold at
//           byte address 0, written by the user only while idle, not enforced.
// Path: an accepted beat passes the input register, then the result register,
//   and is offered on out_valid from the result register.
// Throughput: one beat per cycle while out_ready is high; the engine's state
//   update is a single short combinational step between the two registers.
// Stall: while a result waits on a low out_ready the result register holds;
//   one more input beat is taken into the input register, then in_ready drops.
// Reset (rst_n low, synchronous): LED dark, blinking off, counters zero,
//   all bars full, threshold back to 60 cm. No clearing pass is needed.
// ----------------------------------------------------------------------------
module distance_blink_bargraph_top
  import dbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dbb_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dbb_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic              in_valid_r, in_valid_nxt;
  dbb_in_t           in_data_r;
  logic              out_valid_r, out_valid_nxt;
  dbb_out_t          out_data_r;
  dbb_out_t          result;
  logic              advance;
  logic              in_fire;
  logic              out_fire;
  logic [DIST_W-1:0] near_threshold;

  dbb_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .near_threshold (near_threshold)
  );

  dbb_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .item           (in_data_r),
    .near_threshold (near_threshold),
    .result         (result)
  );

  // handshake control
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // backpressure only when the input register is occupied
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room to spare");

  // an accepted beat lands in the input register
  a_in_land: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_valid_r)
    else $error("accepted beat lost");

  // a dark LED shows no color
  a_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.led_lit |-> out_data_r.led_red == '0 && out_data_r.led_green == '0)
    else $error("color shown while dark");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for distance_blink_bargraph_top
// Drives ticks and distance samples with bursty valid and a stalling receiver,
// predicts LED color and bar heights per beat, and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import dbb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 275;
  localparam int NUM_PHASES  = 6;
  localparam int DRAIN_WAIT  = 4;
  localparam int MAX_REPORTS = 10;

  // byte addresses: index 1 has no register behind it
  localparam logic [ADDR_W-1:0] ADDR_NEAR_THRESHOLD = {REG_NEAR_THRESHOLD, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPARE          = 3'd4;

  // results that can be typed in directly
  localparam dbb_out_t DARK_FULL = {8'd0, 8'd0, 1'b0, {HIST_DEPTH{BAR_FULL}}};
  localparam dbb_out_t RED_FULL  = {BLINK_LEVEL, 8'd0, 1'b1, {HIST_DEPTH{BAR_FULL}}};
  localparam dbb_out_t RED_FAR   = {BLINK_LEVEL, 8'd0, 1'b1, 4'd0, {7{BAR_FULL}}};
  localparam dbb_out_t NO_TYPED  = '0;

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_HALF, READY_RARE} ready_mode_t;

  typedef struct packed {
    logic              func;
    logic [DIST_W-1:0] dist_cm;
    logic [12:0]       reps;
    logic              typed;
    dbb_out_t          want;
  } stim_row_t;

  // directed sequence: reps beats of the same item per row
  localparam stim_row_t PLAN [17] = '{
    '{FUNC_TICK,   10'd0,    13'd3,    1'b1, DARK_FULL},  // idle after reset
    '{FUNC_TICK,   10'd1023, 13'd4100, 1'b1, DARK_FULL},  // count saturates, dist ignored
    '{FUNC_SAMPLE, 10'd0,    13'd1,    1'b1, DARK_FULL},  // sample never toggles
    '{FUNC_TICK,   10'h2AA,  13'd1,    1'b1, RED_FULL},   // saturated count: on at once
    '{FUNC_SAMPLE, 10'd1023, 13'd1,    1'b1, RED_FAR},    // farthest, empty bar
    '{FUNC_SAMPLE, 10'd59,   13'd1,    1'b0, NO_TYPED},   // just below threshold
    '{FUNC_SAMPLE, 10'd60,   13'd1,    1'b0, NO_TYPED},   // at threshold: green
    '{FUNC_SAMPLE, 10'd79,   13'd1,    1'b0, NO_TYPED},
    '{FUNC_SAMPLE, 10'd80,   13'd1,    1'b0, NO_TYPED},
    '{FUNC_SAMPLE, 10'd9,    13'd1,    1'b0, NO_TYPED},
    '{FUNC_SAMPLE, 10'd10,   13'd1,    1'b0, NO_TYPED},
    '{FUNC_SAMPLE, 10'h155,  13'd1,    1'b0, NO_TYPED},   // history wraps from here
    '{FUNC_SAMPLE, 10'h2AA,  13'd1,    1'b0, NO_TYPED},
    '{FUNC_SAMPLE, 10'd0,    13'd1,    1'b0, NO_TYPED},   // shortest period
    '{FUNC_TICK,   10'd0,    13'd100,  1'b0, NO_TYPED},   // turns off
    '{FUNC_SAMPLE, 10'd75,   13'd1,    1'b0, NO_TYPED},
    '{FUNC_TICK,   10'd1023, 13'd270,  1'b0, NO_TYPED}    // back on in green
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  dbb_in_t           in_data;
  logic              out_valid;
  logic              out_ready = 1'b0;
  dbb_out_t          out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // indicator state as the bench sees it
  logic [DIST_W-1:0]  thresh     = THRESH_RESET;
  logic               blink_on   = 1'b0;
  logic               lit        = 1'b0;
  logic [COUNT_W-1:0] elapsed    = '0;
  logic [COUNT_W-1:0] period     = '0;
  logic [LEVEL_W-1:0] pend_red   = '0;
  logic [LEVEL_W-1:0] pend_green = '0;
  logic [LEVEL_W-1:0] shown_red  = '0;
  logic [LEVEL_W-1:0] shown_green = '0;
  logic [DIST_W-1:0]  hist [HIST_DEPTH] = '{default: '0};
  logic [2:0]         head       = '0;

  dbb_out_t expected_displays [$];

  int          fail_count   = 0;
  int          item_count   = 0;
  int          sample_count = 0;
  int          result_count = 0;
  int          toggle_count = 0;
  int          cycle_count  = 0;
  int          burst_left   = 0;
  int          ready_left   = 0;
  ready_mode_t ready_mode   = READY_ALWAYS;
  logic        last_lit     = 1'b0;

  distance_blink_bargraph_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_displays.size());
      $display("FAIL distance_blink_bargraph_top");
      $finish;
    end
  end

  function automatic logic [BAR_W-1:0] bar_of(input dbb_out_t s, input int c);
    return s[31-4*c -: 4];
  endfunction

  // advance the indicator by one beat and return the display it shows
  function automatic dbb_out_t indicator_step(input dbb_in_t beat);
    logic [31:0]       bars;
    logic [DIST_W-1:0] h;
    int unsigned       q;
    if (beat.func == FUNC_SAMPLE) begin
      blink_on = 1'b1;
      period   = COUNT_W'((32'(beat.distance_cm) * 900) / 400 + 100);
      if (beat.distance_cm < thresh) begin
        pend_red   = BLINK_LEVEL;
        pend_green = '0;
      end else begin
        pend_red   = '0;
        pend_green = BLINK_LEVEL;
      end
      head       = head - 3'd1;
      hist[head] = beat.distance_cm;
    end else begin
      if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
      if (blink_on && elapsed >= period) begin
        if (lit) begin
          shown_red   = '0;
          shown_green = '0;
        end else begin
          shown_red   = pend_red;
          shown_green = pend_green;
        end
        lit     = ~lit;
        elapsed = '0;
      end
    end
    // column 0 is the newest sample
    for (int c = 0; c < HIST_DEPTH; c++) begin
      h = hist[3'(head + c)];
      q = h / 10;
      bars[31-4*c -: 4] = (q < 8) ? BAR_W'(8 - q) : 4'd0;
    end
    return {lit ? shown_red : 8'd0, lit ? shown_green : 8'd0, lit, bars};
  endfunction

  // distances: mostly within bar range, some anywhere, near threshold, or at 0 or 1023
  function automatic logic [DIST_W-1:0] pick_distance();
    int d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: d = $urandom_range(0, 90);
      6, 7:             d = $urandom_range(0, 1023);
      8:                d = int'(thresh) + int'($urandom_range(0, 4)) - 2;
      default:          d = ($urandom_range(0, 1) == 0) ? 0 : 1023;
    endcase
    if (d < 0) d = 0;
    if (d > 1023) d = 1023;
    return DIST_W'(d);
  endfunction

  // one input beat; bursts of back-to-back beats separated by random gaps
  task automatic send_beat(input logic func, input logic [DIST_W-1:0] dist_cm,
                           input logic typed, input dbb_out_t want);
    int       gap;
    dbb_in_t  beat;
    dbb_out_t predicted;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.func        = func;
    beat.distance_cm = dist_cm;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    predicted = indicator_step(beat);
    expected_displays.push_back(typed ? want : predicted);
    item_count++;
    if (func == FUNC_SAMPLE) sample_count++;
  endtask

  // drop valid, let every result come out, then allow the pipeline to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_displays.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // one config transfer: setup, then access; reads are checked on completion
  task automatic cfg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr && addr == ADDR_NEAR_THRESHOLD) thresh = data[DIST_W-1:0];
    if (!wr && prdata[DIST_W-1:0] !== thresh) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("ERROR: threshold readback expected %0d, got %0d",
                 thresh, prdata[DIST_W-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // compare a result beat with the oldest expectation
  task automatic check_display(input dbb_out_t got);
    dbb_out_t want;
    string    diff;
    if (expected_displays.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("ERROR: result beat with nothing expected: red %0d green %0d lit %0d bars %h",
                 got.led_red, got.led_green, got.led_lit, got[31:0]);
      return;
    end
    want = expected_displays.pop_front();
    diff = "";
    if (got.led_red !== want.led_red) diff = {diff, " led_red"};
    if (got.led_green !== want.led_green) diff = {diff, " led_green"};
    if (got.led_lit !== want.led_lit) diff = {diff, " led_lit"};
    for (int c = 0; c < HIST_DEPTH; c++)
      if (bar_of(got, c) !== bar_of(want, c)) diff = {diff, $sformatf(" bar_%0d", c)};
    if (diff != "") begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("ERROR: result %0d differs in%s", result_count, diff);
        $display("  expected red %0d green %0d lit %0d bars %h",
                 want.led_red, want.led_green, want.led_lit, want[31:0]);
        $display("  actual   red %0d green %0d lit %0d bars %h",
                 got.led_red, got.led_green, got.led_lit, got[31:0]);
      end
    end
    if (got.led_lit !== last_lit) toggle_count++;
    last_lit = got.led_lit;
    result_count++;
  endtask

  // receiver: take results, stall in patterns re-chosen at random over the run
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_display(out_data);
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(4, 60);
    end
    ready_left--;
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      READY_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
      default:      out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // stimulus
  initial begin
    logic [DIST_W-1:0] phase_thresh [NUM_PHASES];
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    phase_thresh[0] = 10'd0;
    phase_thresh[1] = 10'd1023;
    phase_thresh[2] = DIST_W'($urandom_range(0, 1023));
    phase_thresh[3] = DIST_W'($urandom_range(0, 100));
    phase_thresh[4] = THRESH_RESET;
    phase_thresh[5] = 10'd40;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset threshold
    foreach (PLAN[r])
      repeat (PLAN[r].reps)
        send_beat(PLAN[r].func, PLAN[r].dist_cm, PLAN[r].typed, PLAN[r].want);

    // random part, one threshold setting per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      cfg_access(1'b1, ADDR_SPARE, $urandom());
      cfg_access(1'b1, ADDR_NEAR_THRESHOLD,
                 ($urandom() & ~32'h3FF) | DATA_W'(phase_thresh[p]));
      cfg_access(1'b0, ADDR_NEAR_THRESHOLD, '0);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 19) == 0) send_beat(FUNC_SAMPLE, pick_distance(), 1'b0, NO_TYPED);
        else send_beat(FUNC_TICK, DIST_W'($urandom()), 1'b0, NO_TYPED);
      end
    end
    wait_idle();

    $display("%0d beats sent (%0d distance samples), %0d results checked",
             item_count, sample_count, result_count);
    $display("%0d LED toggles seen over %0d threshold settings, %0d mismatches",
             toggle_count, NUM_PHASES + 1, fail_count);
    if (fail_count == 0 && expected_displays.size() == 0) begin
      $display("PASS distance_blink_bargraph_top");
    end else begin
      $display("FAIL distance_blink_bargraph_top");
    end
    $finish;
  end

endmodule

@@ distance_blink_bargraph_top.f @@
rtl/core/dbb_pkg.sv
rtl/core/dbb_cfg.sv
rtl/core/dbb_engine.sv
rtl/core/distance_blink_bargraph_top.sv
test/testbench.sv
